// ----- sv/eps_pkg.sv -----
// Shared types, character codes and prefix tables for the edge predicate scanner.
package eps_pkg;

  localparam logic [11:0] FieldMax = 12'hFFF;

  localparam logic [7:0] ChUnder  = 8'h5F;
  localparam logic [7:0] ChLowA   = 8'h61;
  localparam logic [7:0] ChLowE   = 8'h65;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLPar   = 8'h28;
  localparam logic [7:0] ChRPar   = 8'h29;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChNul    = 8'h00;

  typedef enum logic [2:0] {
    PH_PREFIX      = 3'd0,
    PH_ACYC_PREFIX = 3'd1,
    PH_EDGE_PREFIX = 3'd2,
    PH_NUM_WS      = 3'd3,
    PH_NUM_SIGN    = 3'd4,
    PH_NUM_DIG     = 3'd5,
    PH_ARG         = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ST_NO_MATCH   = 3'd0,
    ST_MATCH      = 3'd1,
    ST_ERR_FIRST  = 3'd2,
    ST_ERR_SECOND = 3'd3,
    ST_TOO_LONG   = 3'd4
  } status_e;

  // Classified byte as passed from the front to the back.
  typedef struct packed {
    logic [7:0] chr;
    logic       last;
    logic       is_end;
    logic       too_long;
    logic       is_space;
    logic       is_digit;
    logic       is_sign;
    logic       is_under;
    logic       is_lpar;
    logic       is_rpar;
    logic       is_comma;
    logic       is_quote;
    logic       is_bslash;
  } class_t;

  function automatic logic [7:0] acyc_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h5F;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h63;
      3'd3:    c = 8'h79;
      3'd4:    c = 8'h63;
      3'd5:    c = 8'h5F;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] edge_char(logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h5F;
      3'd1:    c = 8'h65;
      3'd2:    c = 8'h64;
      3'd3:    c = 8'h67;
      3'd4:    c = 8'h65;
      3'd5:    c = 8'h28;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ----- sv/eps_front.sv -----
// Front end: byte classifier and string position counter.
module eps_front #(
  parameter int MAX_LEN = 4096,
  localparam int PosW = $clog2(MAX_LEN + 2)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            char_byte_i,
  input  logic                  last_i,
  input  logic                  push_i,
  output eps_pkg::class_t       cls_o,
  output logic [PosW-1:0]       pos_o
);

  logic [PosW-1:0] pos_q, pos_d;

  always_comb begin
    cls_o.chr       = char_byte_i;
    cls_o.last      = last_i;
    cls_o.is_end    = (char_byte_i == eps_pkg::ChNul);
    cls_o.too_long  = (pos_q >= PosW'(MAX_LEN));
    cls_o.is_space  = (char_byte_i == eps_pkg::ChSpace) ||
                      ((char_byte_i >= eps_pkg::ChTab) && (char_byte_i <= eps_pkg::ChCr));
    cls_o.is_digit  = (char_byte_i >= eps_pkg::ChZero) && (char_byte_i <= eps_pkg::ChNine);
    cls_o.is_sign   = (char_byte_i == eps_pkg::ChPlus) || (char_byte_i == eps_pkg::ChMinus);
    cls_o.is_under  = (char_byte_i == eps_pkg::ChUnder);
    cls_o.is_lpar   = (char_byte_i == eps_pkg::ChLPar);
    cls_o.is_rpar   = (char_byte_i == eps_pkg::ChRPar);
    cls_o.is_comma  = (char_byte_i == eps_pkg::ChComma);
    cls_o.is_quote  = (char_byte_i == eps_pkg::ChQuote);
    cls_o.is_bslash = (char_byte_i == eps_pkg::ChBslash);
  end

  assign pos_o = pos_q;

  // Restart at each string end, saturate one past the length limit.
  always_comb begin
    pos_d = pos_q;
    if (push_i) begin
      if (cls_o.is_end || last_i) begin
        pos_d = '0;
      end else if (pos_q <= PosW'(MAX_LEN)) begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- sv/eps_fifo.sv -----
// Two-entry item queue between front and back.
module eps_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;
  logic             push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- sv/eps_back.sv -----
// Back end: predicate state machine and result register.
module eps_back #(
  parameter int MAX_LEN = 4096,
  localparam int PosW = $clog2(MAX_LEN + 2)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  ent_valid_i,
  output logic                  ent_pop_o,
  input  eps_pkg::class_t       cls_i,
  input  logic [PosW-1:0]       pos_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic [11:0]           first_start_o,
  output logic [11:0]           first_length_o,
  output logic [11:0]           second_start_o,
  output logic [11:0]           second_length_o,
  output logic [11:0]           consumed_o
);

  eps_pkg::phase_e  phase_q, phase_d;
  logic [PosW-1:0]  depth_q, depth_d;
  logic             inq_q, inq_d, esc_q, esc_d, done_q, done_d;
  logic [PosW-1:0]  sm_q [3];
  logic [PosW-1:0]  sm_d [3];
  logic [1:0]       item_q, item_d;

  logic             pop, hit, fin;
  eps_pkg::status_e res_st;
  logic [PosW-1:0]  r_fs, r_fl, r_ss, r_sl, r_cons;
  logic [PosW-1:0]  end_pos, arg_start, arg_len, p_inc;

  logic             out_valid_q;
  logic [2:0]       status_q;
  logic [11:0]      fs_q, fl_q, ss_q, sl_q, cons_q;

  function automatic logic [11:0] sat12(logic [PosW-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'(eps_pkg::FieldMax)) ? eps_pkg::FieldMax : w[11:0];
  endfunction

  assign pop       = ent_valid_i && (!out_valid_q || out_ready_i);
  assign ent_pop_o = pop;
  assign fin       = cls_i.is_end || cls_i.last;
  assign p_inc     = pos_i + PosW'(1);
  assign end_pos   = (cls_i.is_end || (pos_i > PosW'(MAX_LEN))) ? pos_i : p_inc;
  assign arg_start = (item_q == 2'd0) ? sm_q[0] : sm_q[2];
  assign arg_len   = pos_i - arg_start;

  always_comb begin
    phase_d = phase_q;
    depth_d = depth_q;
    inq_d   = inq_q;
    esc_d   = esc_q;
    sm_d    = sm_q;
    item_d  = item_q;
    done_d  = done_q;
    hit     = 1'b0;
    res_st  = eps_pkg::ST_NO_MATCH;
    r_fs    = '0;
    r_fl    = '0;
    r_ss    = '0;
    r_sl    = '0;
    r_cons  = '0;

    if (pop && !done_q && !cls_i.is_end) begin
      if (cls_i.too_long) begin
        hit    = 1'b1;
        res_st = eps_pkg::ST_TOO_LONG;
      end else begin
        case (phase_q)
          eps_pkg::PH_PREFIX: begin
            if (pos_i == '0) begin
              hit = !cls_i.is_under;
            end else if (cls_i.chr == eps_pkg::ChLowA) begin
              phase_d = eps_pkg::PH_ACYC_PREFIX;
            end else if (cls_i.chr == eps_pkg::ChLowE) begin
              phase_d = eps_pkg::PH_EDGE_PREFIX;
            end else begin
              hit = 1'b1;
            end
          end
          eps_pkg::PH_ACYC_PREFIX: begin
            if ((pos_i > PosW'(5)) || (cls_i.chr != eps_pkg::acyc_char(pos_i[2:0]))) begin
              hit = 1'b1;
            end else if (pos_i == PosW'(5)) begin
              phase_d = eps_pkg::PH_NUM_WS;
              item_d  = 2'd0;
            end
          end
          eps_pkg::PH_EDGE_PREFIX: begin
            if ((pos_i > PosW'(5)) || (cls_i.chr != eps_pkg::edge_char(pos_i[2:0]))) begin
              hit = 1'b1;
            end else if (pos_i == PosW'(5)) begin
              phase_d  = eps_pkg::PH_ARG;
              item_d   = 2'd0;
              sm_d[0]  = p_inc;
            end
          end
          eps_pkg::PH_NUM_WS: begin
            if (cls_i.is_sign) begin
              phase_d = eps_pkg::PH_NUM_SIGN;
            end else if (cls_i.is_digit) begin
              phase_d = eps_pkg::PH_NUM_DIG;
            end else if (!cls_i.is_space) begin
              hit = 1'b1;
            end
          end
          eps_pkg::PH_NUM_SIGN: begin
            if (cls_i.is_digit) begin
              phase_d = eps_pkg::PH_NUM_DIG;
            end else begin
              hit = 1'b1;
            end
          end
          eps_pkg::PH_NUM_DIG: begin
            if (cls_i.is_digit) begin
              phase_d = eps_pkg::PH_NUM_DIG;
            end else if (item_q >= 2'd2) begin
              // First non-digit after the third number closes the match.
              hit    = 1'b1;
              res_st = eps_pkg::ST_MATCH;
              r_fs   = sm_q[0];
              r_fl   = sm_q[1] - PosW'(1) - sm_q[0];
              r_ss   = sm_q[1];
              r_sl   = pos_i - sm_q[1];
              r_cons = pos_i;
            end else if (!cls_i.is_under) begin
              hit = 1'b1;
            end else begin
              sm_d[item_q] = p_inc;
              item_d       = item_q + 2'd1;
              phase_d      = eps_pkg::PH_NUM_WS;
            end
          end
          eps_pkg::PH_ARG: begin
            if (inq_q) begin
              if (esc_q) begin
                esc_d = 1'b0;
              end else if (cls_i.is_quote) begin
                inq_d = 1'b0;
              end else begin
                esc_d = cls_i.is_bslash;
              end
            end else if (cls_i.is_lpar) begin
              depth_d = depth_q + PosW'(1);
            end else if (cls_i.is_rpar && (depth_q != '0)) begin
              depth_d = depth_q - PosW'(1);
            end else if (cls_i.is_rpar || (cls_i.is_comma && (depth_q == '0))) begin
              // Argument closes at depth zero.
              if (item_q == 2'd0) begin
                if (!cls_i.is_comma || (arg_len == '0)) begin
                  hit    = 1'b1;
                  res_st = eps_pkg::ST_ERR_FIRST;
                end else begin
                  sm_d[1] = arg_len;
                  sm_d[2] = p_inc;
                  item_d  = 2'd1;
                  depth_d = '0;
                end
              end else if (!cls_i.is_rpar || (arg_len == '0)) begin
                hit    = 1'b1;
                res_st = eps_pkg::ST_ERR_SECOND;
              end else begin
                hit    = 1'b1;
                res_st = eps_pkg::ST_MATCH;
                r_fs   = sm_q[0];
                r_fl   = sm_q[1];
                r_ss   = arg_start;
                r_sl   = arg_len;
                r_cons = p_inc;
              end
            end else if (cls_i.is_quote) begin
              inq_d = 1'b1;
              esc_d = 1'b0;
            end
          end
          default: begin
            hit = 1'b1;
          end
        endcase
      end
    end

    // End of string with no result yet: decide on the state left by this byte.
    if (pop && fin && !(done_q || hit)) begin
      hit = 1'b1;
      if ((phase_d == eps_pkg::PH_NUM_DIG) && (item_d == 2'd2)) begin
        res_st = eps_pkg::ST_MATCH;
        r_fs   = sm_q[0];
        r_fl   = sm_q[1] - PosW'(1) - sm_q[0];
        r_ss   = sm_q[1];
        r_sl   = end_pos - sm_q[1];
        r_cons = end_pos;
      end else if (phase_d == eps_pkg::PH_ARG) begin
        res_st = (item_d == 2'd0) ? eps_pkg::ST_ERR_FIRST : eps_pkg::ST_ERR_SECOND;
      end else begin
        res_st = eps_pkg::ST_NO_MATCH;
      end
    end

    if (hit) begin
      done_d = 1'b1;
    end

    if (pop && fin) begin
      phase_d = eps_pkg::PH_PREFIX;
      depth_d = '0;
      inq_d   = 1'b0;
      esc_d   = 1'b0;
      sm_d[0] = '0;
      sm_d[1] = '0;
      sm_d[2] = '0;
      item_d  = 2'd0;
      done_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= eps_pkg::PH_PREFIX;
      depth_q     <= '0;
      inq_q       <= 1'b0;
      esc_q       <= 1'b0;
      sm_q[0]     <= '0;
      sm_q[1]     <= '0;
      sm_q[2]     <= '0;
      item_q      <= 2'd0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      depth_q <= depth_d;
      inq_q   <= inq_d;
      esc_q   <= esc_d;
      sm_q    <= sm_d;
      item_q  <= item_d;
      done_q  <= done_d;
      if (pop && hit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && hit) begin
      status_q <= res_st;
      fs_q     <= sat12(r_fs);
      fl_q     <= sat12(r_fl);
      ss_q     <= sat12(r_ss);
      sl_q     <= sat12(r_sl);
      cons_q   <= sat12(r_cons);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign first_start_o   = fs_q;
  assign first_length_o  = fl_q;
  assign second_start_o  = ss_q;
  assign second_length_o = sl_q;
  assign consumed_o      = cons_q;

endmodule

// ----- sv/edge_predicate_scanner_core.sv -----
// Top level of the edge predicate scanner: front end, item queue and back end.
//
// The scanner takes one string byte per item and reports, once per string,
// whether the string opens with "_acyc_<n>_<n>_<n>" or "_edge(a,b)", with
// offsets and lengths of both node texts and the count of bytes consumed.
// A 0 byte or an item with last set ends the string; a result is delivered as
// soon as the outcome is known and the rest of the string is swallowed.
// Sustained rate is one item per clock cycle in both directions while the result
// output does not stall: the front end classifies a byte and tracks its offset
// in the cycle it is accepted, a two-entry queue holds it, and the back end
// updates its phase state machine for one item per cycle. An accepted item is
// written into the queue; the back end takes it from there and loads the result
// register as it does; the result is offered from then on until it is taken.
// Offsets saturate at 4095; a byte at offset MAX_LEN or beyond gives the
// too-long status.
module edge_predicate_scanner_core #(
  parameter int MAX_LEN = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [11:0] first_start_o,
  output logic [11:0] first_length_o,
  output logic [11:0] second_start_o,
  output logic [11:0] second_length_o,
  output logic [11:0] consumed_o
);

  localparam int PosW = $clog2(MAX_LEN + 2);
  localparam int EntW = $bits(eps_pkg::class_t) + PosW;

  eps_pkg::class_t front_cls, back_cls;
  logic [PosW-1:0] front_pos, back_pos;
  logic [EntW-1:0] q_data;
  logic            push, q_valid, q_pop;

  // Accept a byte whenever the queue has a free slot.
  assign push = in_valid_i && in_ready_o;

  eps_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_byte_i (char_byte_i),
    .last_i      (last_i),
    .push_i      (push),
    .cls_o       (front_cls),
    .pos_o       (front_pos)
  );

  // Hold classified items until the back end takes them.
  eps_fifo #(
    .Width (EntW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   ({front_cls, front_pos}),
    .out_valid_o (q_valid),
    .out_ready_i (q_pop),
    .out_data_o  (q_data)
  );

  assign {back_cls, back_pos} = q_data;

  // Advance the predicate state machine and register the result.
  eps_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ent_valid_i     (q_valid),
    .ent_pop_o       (q_pop),
    .cls_i           (back_cls),
    .pos_i           (back_pos),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .first_start_o   (first_start_o),
    .first_length_o  (first_length_o),
    .second_start_o  (second_start_o),
    .second_length_o (second_length_o),
    .consumed_o      (consumed_o)
  );

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the edge predicate scanner: directed strings, then random ones.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import eps_pkg::*;

  localparam int MaxLen     = 4096;
  localparam int RandItems  = 400;
  localparam int HoldCycles = 300;
  localparam int StallLimit = 3000;
  localparam int IdlePct    = 17;

  localparam logic [47:0] AcycWord = "_acyc_";
  localparam logic [47:0] EdgeWord = "_edge(";

  typedef struct packed {
    status_e     status;
    logic [11:0] first_start;
    logic [11:0] first_length;
    logic [11:0] second_start;
    logic [11:0] second_length;
    logic [11:0] consumed;
  } scan_res_t;

  typedef enum int {
    END_NUL,
    END_LAST,
    END_NUL_LAST
  } str_end_e;

  typedef struct {
    logic [7:0] chr;
    logic       lst;
    int         tag;
  } scan_item_t;

  typedef struct {
    string     text;
    str_end_e  term;
    bit        typed;
    scan_res_t res;
  } dir_row_t;

  localparam scan_res_t NoMatch   = '{ST_NO_MATCH, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
  localparam scan_res_t ErrFirst  = '{ST_ERR_FIRST, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
  localparam scan_res_t ErrSecond = '{ST_ERR_SECOND, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};
  localparam scan_res_t TooLong   = '{ST_TOO_LONG, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_byte_i = '0;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [11:0] first_start_o;
  logic [11:0] first_length_o;
  logic [11:0] second_start_o;
  logic [11:0] second_length_o;
  logic [11:0] consumed_o;

  edge_predicate_scanner_core #(
    .MAX_LEN(MaxLen)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .char_byte_i    (char_byte_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .first_start_o  (first_start_o),
    .first_length_o (first_length_o),
    .second_start_o (second_start_o),
    .second_length_o(second_length_o),
    .consumed_o     (consumed_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Stimulus and expectation stores.
  scan_item_t  feed_q[$];
  scan_res_t   typed_res[$];
  scan_res_t   scan_exp_q[$];
  logic [7:0]  txt_q[$];
  dir_row_t    dir_tab [21];

  int          fault_cnt;
  int          res_cnt;
  int          acc_idx;
  int          idle_cycles;
  int unsigned cyc;
  logic        calm;

  // Scanner state as the predictor sees it.
  int unsigned scan_pos;
  phase_e      scan_phase;
  int unsigned paren_lvl;
  bit          quoted;
  bit          escaped;
  int unsigned span_mark [3];
  int unsigned field_idx;
  bit          reported;

  scan_res_t   pred_res;
  scan_res_t   seen_res;

  assign calm = (cyc >= 1500) && (cyc < 5500);

  always @(posedge clk_i) cyc <= cyc + 1;

  function automatic logic [11:0] sat12(int unsigned v);
    return (v > 4095) ? FieldMax : v[11:0];
  endfunction

  function automatic logic [7:0] word_char(logic [47:0] w, int unsigned p);
    return w[8*(5-p) +: 8];
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == ChSpace || (c >= ChTab && c <= ChCr);
  endfunction

  function automatic void reset_scan();
    scan_pos     = 0;
    scan_phase   = PH_PREFIX;
    paren_lvl    = 0;
    quoted       = 1'b0;
    escaped      = 1'b0;
    span_mark[0] = 0;
    span_mark[1] = 0;
    span_mark[2] = 0;
    field_idx    = 0;
    reported     = 1'b0;
  endfunction

  // Build a result and mark the string as answered.
  function automatic scan_res_t report(status_e st, int unsigned fs, int unsigned fl,
                                       int unsigned ss, int unsigned sl, int unsigned cons);
    scan_res_t r;
    r.status        = st;
    r.first_start   = sat12(fs);
    r.first_length  = sat12(fl);
    r.second_start  = sat12(ss);
    r.second_length = sat12(sl);
    r.consumed      = sat12(cons);
    reported        = 1'b1;
    return r;
  endfunction

  // Acyclic match: node spans are the second and third numbers.
  function automatic scan_res_t acyc_hit(int unsigned stop);
    return report(ST_MATCH, span_mark[0], span_mark[1] - 1 - span_mark[0],
                  span_mark[1], stop - span_mark[1], stop);
  endfunction

  function automatic scan_res_t close_string();
    if (scan_phase == PH_NUM_DIG && field_idx == 2) return acyc_hit(scan_pos);
    if (scan_phase == PH_ARG)
      return report(field_idx == 0 ? ST_ERR_FIRST : ST_ERR_SECOND, 0, 0, 0, 0, 0);
    return report(ST_NO_MATCH, 0, 0, 0, 0, 0);
  endfunction

  // Handle a ',' or ')' at depth zero inside the edge form.
  function automatic bit close_arg(input logic [7:0] c, input int unsigned p,
                                   output scan_res_t r);
    int unsigned start;
    int unsigned len;
    start = (field_idx == 0) ? span_mark[0] : span_mark[2];
    len   = p - start;
    r     = NoMatch;
    if (field_idx == 0) begin
      if (c != ChComma || len == 0) begin
        r = report(ST_ERR_FIRST, 0, 0, 0, 0, 0);
        return 1'b1;
      end
      span_mark[1] = len;
      span_mark[2] = p + 1;
      field_idx    = 1;
      paren_lvl    = 0;
      return 1'b0;
    end
    if (c != ChRPar || len == 0) begin
      r = report(ST_ERR_SECOND, 0, 0, 0, 0, 0);
      return 1'b1;
    end
    r = report(ST_MATCH, span_mark[0], span_mark[1], start, len, p + 1);
    return 1'b1;
  endfunction

  function automatic bit scan_char(input logic [7:0] c, output scan_res_t r);
    int unsigned p;
    p = scan_pos;
    r = NoMatch;
    if (p >= MaxLen) begin
      r = report(ST_TOO_LONG, 0, 0, 0, 0, 0);
      return 1'b1;
    end
    case (scan_phase)
      PH_PREFIX: begin
        if (p == 0 && c == ChUnder) return 1'b0;
        if (p != 0 && c == ChLowA) begin
          scan_phase = PH_ACYC_PREFIX;
          return 1'b0;
        end
        if (p != 0 && c == ChLowE) begin
          scan_phase = PH_EDGE_PREFIX;
          return 1'b0;
        end
      end
      PH_ACYC_PREFIX: begin
        if (p <= 5 && c == word_char(AcycWord, p)) begin
          if (p == 5) begin
            scan_phase = PH_NUM_WS;
            field_idx  = 0;
          end
          return 1'b0;
        end
      end
      PH_EDGE_PREFIX: begin
        if (p <= 5 && c == word_char(EdgeWord, p)) begin
          if (p == 5) begin
            scan_phase   = PH_ARG;
            field_idx    = 0;
            span_mark[0] = p + 1;
          end
          return 1'b0;
        end
      end
      PH_NUM_WS: begin
        if (is_blank(c)) return 1'b0;
        if (c == ChPlus || c == ChMinus) begin
          scan_phase = PH_NUM_SIGN;
          return 1'b0;
        end
        if (is_digit(c)) begin
          scan_phase = PH_NUM_DIG;
          return 1'b0;
        end
      end
      PH_NUM_SIGN: begin
        if (is_digit(c)) begin
          scan_phase = PH_NUM_DIG;
          return 1'b0;
        end
      end
      PH_NUM_DIG: begin
        if (is_digit(c)) return 1'b0;
        // The byte after the third number completes the match unconsumed.
        if (field_idx >= 2) begin
          r = acyc_hit(p);
          return 1'b1;
        end
        if (c == ChUnder) begin
          span_mark[field_idx] = p + 1;
          field_idx++;
          scan_phase = PH_NUM_WS;
          return 1'b0;
        end
      end
      PH_ARG: begin
        if (quoted) begin
          if (escaped) escaped = 1'b0;
          else if (c == ChQuote) quoted = 1'b0;
          else escaped = (c == ChBslash);
          return 1'b0;
        end
        if (c == ChLPar) begin
          paren_lvl++;
          return 1'b0;
        end
        if (c == ChRPar) begin
          if (paren_lvl == 0) return close_arg(c, p, r);
          paren_lvl--;
          return 1'b0;
        end
        if (c == ChComma) begin
          if (paren_lvl == 0) return close_arg(c, p, r);
          return 1'b0;
        end
        if (c == ChQuote) begin
          quoted  = 1'b1;
          escaped = 1'b0;
        end
        return 1'b0;
      end
      default: ;
    endcase
    r = report(ST_NO_MATCH, 0, 0, 0, 0, 0);
    return 1'b1;
  endfunction

  // Advance the scanner by one accepted item; return 1 when it yields a result.
  function automatic bit predict_item(input logic [7:0] c, input logic lst,
                                      output scan_res_t r);
    bit hit;
    hit = 1'b0;
    r   = NoMatch;
    if (c == ChNul) begin
      if (!reported) begin
        r   = close_string();
        hit = 1'b1;
      end
      reset_scan();
      return hit;
    end
    if (!reported) hit = scan_char(c, r);
    if (scan_pos <= MaxLen) scan_pos++;
    if (lst) begin
      if (!reported) begin
        r   = close_string();
        hit = 1'b1;
      end
      reset_scan();
    end
    return hit;
  endfunction

  // String assembly.
  function automatic void put_char(logic [7:0] c);
    txt_q.push_back(c);
  endfunction

  function automatic void put_str(string s);
    int i;
    for (i = 0; i < s.len(); i++) txt_q.push_back(s[i]);
  endfunction

  function automatic void put_plain();
    if ($urandom_range(0, 1) != 0) put_char(8'(ChLowA + $urandom_range(0, 25)));
    else put_char(8'(ChZero + $urandom_range(0, 9)));
  endfunction

  function automatic void put_num();
    repeat ($urandom_range(0, 2))
      put_char($urandom_range(0, 5) == 0 ? ChSpace : 8'(ChTab + $urandom_range(0, 4)));
    case ($urandom_range(0, 2))
      1:       put_char(ChPlus);
      2:       put_char(ChMinus);
      default: ;
    endcase
    repeat ($urandom_range(1, 4)) put_char(8'(ChZero + $urandom_range(0, 9)));
  endfunction

  function automatic void put_arg();
    int n;
    int k;
    if ($urandom_range(0, 19) == 0) return;
    n = $urandom_range(1, 4);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0, 1: put_plain();
        2: begin
          put_char(ChLPar);
          put_plain();
          put_char(ChComma);
          put_plain();
          put_char(ChRPar);
        end
        default: begin
          put_char(ChQuote);
          repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 3))
              0: put_char(ChComma);
              1: put_char(ChRPar);
              2: begin
                put_char(ChBslash);
                put_char(8'($urandom_range(1, 255)));
              end
              default: put_plain();
            endcase
          end
          put_char(ChQuote);
        end
      endcase
    end
  endfunction

  // Move the assembled string into the feed, with its terminator.
  function automatic void flush_string(str_end_e term, bit typed, scan_res_t res);
    int tag;
    int i;
    scan_item_t it;
    tag = -1;
    if (typed) begin
      tag = typed_res.size();
      typed_res.push_back(res);
    end
    it.tag = tag;
    for (i = 0; i < txt_q.size(); i++) begin
      it.chr = txt_q[i];
      it.lst = (term == END_LAST) && (i == txt_q.size() - 1);
      feed_q.push_back(it);
    end
    if (term != END_LAST || txt_q.size() == 0) begin
      it.chr = ChNul;
      it.lst = (term == END_NUL_LAST);
      feed_q.push_back(it);
    end
    txt_q = {};
  endfunction

  function automatic void check_field(string name, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      fault_cnt++;
      if (fault_cnt <= 10)
        $display("mismatch on result %0d, %s: expected %0d, got %0d",
                 res_cnt, name, want, got);
    end
  endfunction

  // Predict on each accepted item, check each accepted result.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      if (predict_item(char_byte_i, last_i, pred_res)) begin
        if (feed_q[acc_idx].tag >= 0) scan_exp_q.push_back(typed_res[feed_q[acc_idx].tag]);
        else scan_exp_q.push_back(pred_res);
      end
      acc_idx++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_res = {status_o, first_start_o, first_length_o, second_start_o,
                  second_length_o, consumed_o};
      if (scan_exp_q.size() == 0) begin
        fault_cnt++;
        if (fault_cnt <= 10)
          $display("unexpected result %0d: status %0d", res_cnt, status_o);
      end else begin
        pred_res = scan_exp_q.pop_front();
        check_field("status", 12'(pred_res.status), 12'(seen_res.status));
        check_field("first_start", pred_res.first_start, seen_res.first_start);
        check_field("first_length", pred_res.first_length, seen_res.first_length);
        check_field("second_start", pred_res.second_start, seen_res.second_start);
        check_field("second_length", pred_res.second_length, seen_res.second_length);
        check_field("consumed", pred_res.consumed, seen_res.consumed);
      end
      res_cnt++;
    end
  end

  // Drop the run if nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus long hold-offs that back the block up.
  initial begin : rx_side
    int next_hold;
    next_hold = 5;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_cnt >= next_hold) begin
        next_hold = next_hold + 35;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        out_ready_i <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  initial begin : main_flow
    int row;
    int idx;
    int rand_items;
    int kind;
    int roll;
    int keep;

    reset_scan();

    dir_tab = '{
      '{"_edge(a,b)", END_NUL, 1'b1,
        '{ST_MATCH, 12'd6, 12'd1, 12'd8, 12'd1, 12'd10}},
      '{"_acyc_1_2_3", END_LAST, 1'b1,
        '{ST_MATCH, 12'd8, 12'd1, 12'd10, 12'd1, 12'd11}},
      '{"", END_NUL, 1'b1, NoMatch},
      '{"x", END_NUL, 1'b1, NoMatch},
      '{"_edge(,b)", END_NUL, 1'b1, ErrFirst},
      '{"_edge(a,)", END_NUL, 1'b1, ErrSecond},
      '{"_edge(a)", END_LAST, 1'b1, ErrFirst},
      '{"_edge(a,b,", END_NUL, 1'b1, ErrSecond},
      '{"_edge(\"ab", END_LAST, 1'b1, ErrFirst},
      '{"_acyc_1_2_", END_NUL, 1'b1, NoMatch},
      '{"_acyc_1x2", END_NUL, 1'b1, NoMatch},
      '{"_acyc_+_", END_NUL, 1'b1, NoMatch},
      '{"_edgf", END_LAST, 1'b1, NoMatch},
      '{"_b", END_NUL, 1'b1, NoMatch},
      '{"\377\200_edge", END_NUL_LAST, 1'b1, NoMatch},
      '{"_e\377", END_NUL, 1'b1, NoMatch},
      '{"_acyc_ +1_\t-22_\015\v\n\f0009xyz", END_NUL, 1'b0, NoMatch},
      '{"_edge(f(1,2),\"a,\\\")\" z)junk", END_NUL, 1'b0, NoMatch},
      '{"_edge((a)),b)", END_NUL, 1'b0, NoMatch},
      '{"_acyc_-0_+0_ 7", END_NUL_LAST, 1'b0, NoMatch},
      '{"_acyc_9_8_76_5", END_LAST, 1'b0, NoMatch}
    };

    // Directed strings, typed expectations where they are obvious.
    for (row = 0; row < 21; row++) begin
      put_str(dir_tab[row].text);
      flush_string(dir_tab[row].term, dir_tab[row].typed, dir_tab[row].res);
    end

    // Longest legal strings: the consumed count hits saturation.
    put_str("_edge(a,");
    repeat (MaxLen - 9) put_str("b");
    put_char(ChRPar);
    flush_string(END_LAST, 1'b0, NoMatch);
    put_str("_acyc_1_2_");
    repeat (MaxLen - 10) put_str("7");
    flush_string(END_LAST, 1'b0, NoMatch);
    // One byte past the limit with the first argument still open.
    put_str("_edge(");
    repeat (MaxLen - 5) put_str("q");
    flush_string(END_NUL, 1'b1, TooLong);

    // Random strings: mostly well formed, some mutated, truncated or noise.
    rand_items = 0;
    while (rand_items < RandItems) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        put_str("_acyc_");
        put_num();
        put_char(ChUnder);
        put_num();
        put_char(ChUnder);
        put_num();
      end else if (kind < 80) begin
        put_str("_edge(");
        put_arg();
        put_char(ChComma);
        put_arg();
        put_char(ChRPar);
      end else if (kind < 90) begin
        put_str($urandom_range(0, 1) != 0 ? "_acyc_" : "_edge(");
        keep = $urandom_range(1, 6);
        while (txt_q.size() > keep) void'(txt_q.pop_back());
      end else begin
        repeat ($urandom_range(1, 8)) put_char(8'($urandom_range(1, 255)));
      end
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        txt_q[$urandom_range(0, txt_q.size() - 1)] = 8'($urandom_range(1, 255));
      end else if (roll < 22 && txt_q.size() > 1) begin
        keep = $urandom_range(1, txt_q.size() - 1);
        while (txt_q.size() > keep) void'(txt_q.pop_back());
      end
      repeat ($urandom_range(0, 3)) put_char(8'($urandom_range(1, 255)));
      rand_items += txt_q.size() + 1;
      flush_string(str_end_e'($urandom_range(0, 2)), 1'b0, NoMatch);
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Offer items; hold each one until accepted, idle only between items.
    idx = 0;
    while (idx < feed_q.size()) begin
      @(posedge clk_i);
      if (in_valid_i && in_ready_o) idx++;
      if (!in_valid_i || in_ready_o) begin
        if (idx < feed_q.size() && (calm || $urandom_range(0, 99) >= IdlePct)) begin
          in_valid_i  <= 1'b1;
          char_byte_i <= feed_q[idx].chr;
          last_i      <= feed_q[idx].lst;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end

    // Drain, then give stray results a chance to show up.
    while (scan_exp_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    if (fault_cnt == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
